// ----- rtl/dptm_pkg.sv -----
// Shared types and constants for the demand paging table manager.
// Depends on nothing; imported by dptm_ctrl and the top level.
`timescale 1ns / 1ps

package dptm_pkg;

   // Fixed widths of the page number and frame fields on the ports
   localparam int VPAGE_W = 20;
   localparam int FRAME_W = 20;
   localparam int STATUS_W = 3;

   // Result codes
   typedef enum logic [STATUS_W-1:0] {
      ST_PAGE_MAPPED  = 3'd0,
      ST_TABLE_MAPPED = 3'd1,
      ST_PRESENT      = 3'd2,
      ST_PROTECTION   = 3'd3,
      ST_FREED        = 3'd4,
      ST_NO_TABLE     = 3'd5,
      ST_NOT_MAPPED   = 3'd6
   } status_type;

   // Operation codes
   typedef enum logic {
      OP_FAULT = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   // Sequencer states
   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_EXEC
   } fsm_type;

   // One result beat
   typedef struct packed {
      status_type         status;
      logic               took_table_frame;
      logic               took_page_frame;
      logic [FRAME_W-1:0] released_frame;
   } rsp_type;

endpackage

// ----- rtl/dptm_ram.sv -----
// Single-port-write, single-port-read synchronous memory with registered read.
// Generic; no package dependency. Used for the directory and the page entries.
`timescale 1ns / 1ps

module dptm_ram #(
   parameter int WIDTH = 21,
   parameter int ADDR_BITS = 10
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data
);

   logic [WIDTH-1:0] mem [2**ADDR_BITS];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/dptm_ctrl.sv -----
// Sequencer for the page table manager: clearing pass, request decode,
// read-modify-write of directory and page entries, result register.
// Depends on dptm_pkg.
`timescale 1ns / 1ps

module dptm_ctrl #(
   parameter int DIR_INDEX_BITS = 10,
   parameter int TABLE_INDEX_BITS = 10,
   parameter int FRAME_BITS = 20
) (
   input  logic                                           clock,
   input  logic                                           reset,
   // request side
   input  logic                                           start,
   output logic                                           busy,
   input  logic                                           req_operation,
   input  logic [dptm_pkg::VPAGE_W-1:0]                   req_virtual_page,
   input  logic                                           req_fault_not_present,
   input  logic [dptm_pkg::FRAME_W-1:0]                   req_spare_table_frame,
   input  logic [dptm_pkg::FRAME_W-1:0]                   req_spare_page_frame,
   // register write
   input  logic                                           csr_valid,
   output logic                                           csr_ready,
   input  logic [dptm_pkg::FRAME_W-1:0]                   csr_data,
   // directory memory
   output logic                                           dir_rd_en,
   output logic [DIR_INDEX_BITS-1:0]                      dir_rd_addr,
   input  logic [FRAME_BITS:0]                            dir_rd_data,
   output logic                                           dir_wr_en,
   output logic [DIR_INDEX_BITS-1:0]                      dir_wr_addr,
   output logic [FRAME_BITS:0]                            dir_wr_data,
   // page entry memory
   output logic                                           pg_rd_en,
   output logic [DIR_INDEX_BITS+TABLE_INDEX_BITS-1:0]     pg_rd_addr,
   input  logic [FRAME_BITS:0]                            pg_rd_data,
   output logic                                           pg_wr_en,
   output logic [DIR_INDEX_BITS+TABLE_INDEX_BITS-1:0]     pg_wr_addr,
   output logic [FRAME_BITS:0]                            pg_wr_data,
   // result
   output logic                                           rsp_strobe,
   output dptm_pkg::rsp_type                              rsp
);

   import dptm_pkg::*;

   localparam int SLOT_BITS = DIR_INDEX_BITS + TABLE_INDEX_BITS;

   fsm_type state_ff, state_in;

   logic [SLOT_BITS-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [FRAME_W-1:0]        cfg_ff, cfg_in;

   logic                      op_ff;
   logic                      np_ff;
   logic [SLOT_BITS-1:0]      slot_ff;
   logic [FRAME_BITS-1:0]     spare_tbl_ff;
   logic [FRAME_BITS-1:0]     spare_pg_ff;

   logic                      strobe_ff, strobe_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      accept;
   logic                      csr_fire;
   logic                      clr_last;
   logic                      clr_dir_phase;
   logic                      clr_tbl0;
   logic [VPAGE_W-1:0]        clr_wide;

   logic                      dir_present;
   logic                      page_present;
   logic                      ex_dir_we;
   logic                      ex_pg_we;
   logic [FRAME_BITS:0]       ex_pg_data;

   // Clearing pass bookkeeping
   assign clr_last      = &clr_cnt_ff;
   assign clr_dir_phase = (clr_cnt_ff[SLOT_BITS-1:DIR_INDEX_BITS] == '0);
   assign clr_tbl0      = (clr_cnt_ff[SLOT_BITS-1:TABLE_INDEX_BITS] == '0);
   assign clr_wide      = VPAGE_W'(clr_cnt_ff[TABLE_INDEX_BITS-1:0]);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            if (clr_last) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (start) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_CLEAR;
         end
      endcase
   end

   // State outputs
   always_comb begin
      busy      = 1'b1;
      csr_ready = 1'b0;
      strobe_in = 1'b0;
      unique case (state_ff)
         FSM_CLEAR: begin
            csr_ready = !clr_dir_phase;
         end
         FSM_IDLE: begin
            busy      = 1'b0;
            csr_ready = 1'b1;
         end
         FSM_EXEC: begin
            strobe_in = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign accept   = start && !busy;
   assign csr_fire = csr_valid && csr_ready;

   // Issue both reads at the accept edge
   assign dir_rd_en   = accept;
   assign dir_rd_addr = req_virtual_page[SLOT_BITS-1:TABLE_INDEX_BITS];
   assign pg_rd_en    = accept;
   assign pg_rd_addr  = req_virtual_page[SLOT_BITS-1:0];

   // Decide the item from the read data
   assign dir_present  = dir_rd_data[FRAME_BITS];
   assign page_present = dir_present && pg_rd_data[FRAME_BITS];

   always_comb begin
      rsp_in     = '{status: ST_PROTECTION, took_table_frame: 1'b0,
                     took_page_frame: 1'b0, released_frame: '0};
      ex_dir_we  = 1'b0;
      ex_pg_we   = 1'b0;
      ex_pg_data = '0;
      if (op_ff == OP_FAULT) begin
         if (np_ff) begin
            ex_dir_we               = !dir_present;
            rsp_in.took_table_frame = !dir_present;
            if (!page_present) begin
               ex_pg_we               = 1'b1;
               ex_pg_data             = {1'b1, spare_pg_ff};
               rsp_in.took_page_frame = 1'b1;
               rsp_in.status = dir_present ? ST_PAGE_MAPPED : ST_TABLE_MAPPED;
            end else begin
               rsp_in.status = ST_PRESENT;
            end
         end
      end else begin
         if (!dir_present) begin
            rsp_in.status = ST_NO_TABLE;
         end else if (!page_present) begin
            rsp_in.status = ST_NOT_MAPPED;
         end else begin
            ex_pg_we              = 1'b1;
            rsp_in.status         = ST_FREED;
            rsp_in.released_frame = FRAME_W'(pg_rd_data[FRAME_BITS-1:0]);
         end
      end
   end

   // Directory write: clearing pass, table install or register write
   always_comb begin
      dir_wr_en   = 1'b0;
      dir_wr_addr = '0;
      dir_wr_data = '0;
      if (state_ff == FSM_CLEAR && clr_dir_phase) begin
         dir_wr_en   = 1'b1;
         dir_wr_addr = clr_cnt_ff[DIR_INDEX_BITS-1:0];
         if (clr_cnt_ff[DIR_INDEX_BITS-1:0] == '0) begin
            dir_wr_data = {1'b1, cfg_ff[FRAME_BITS-1:0]};
         end
      end else if (state_ff == FSM_EXEC && ex_dir_we) begin
         dir_wr_en   = 1'b1;
         dir_wr_addr = slot_ff[SLOT_BITS-1:TABLE_INDEX_BITS];
         dir_wr_data = {1'b1, spare_tbl_ff};
      end else if (csr_fire) begin
         dir_wr_en   = 1'b1;
         dir_wr_data = {1'b1, csr_data[FRAME_BITS-1:0]};
      end
   end

   // Page entry write: clearing pass or item update
   always_comb begin
      pg_wr_en   = 1'b0;
      pg_wr_addr = slot_ff;
      pg_wr_data = ex_pg_data;
      if (state_ff == FSM_CLEAR) begin
         pg_wr_en   = 1'b1;
         pg_wr_addr = clr_cnt_ff;
         pg_wr_data = clr_tbl0 ? {1'b1, clr_wide[FRAME_BITS-1:0]} : '0;
      end else if (state_ff == FSM_EXEC) begin
         pg_wr_en = ex_pg_we;
      end
   end

   assign clr_cnt_in = (state_ff == FSM_CLEAR) ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   assign cfg_in     = csr_fire ? csr_data : cfg_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FSM_CLEAR;
         clr_cnt_ff <= '0;
         cfg_ff     <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         cfg_ff     <= cfg_in;
         strobe_ff  <= strobe_in;
      end
   end

   // Hold the request beat for the execute cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= req_operation;
         np_ff        <= req_fault_not_present;
         slot_ff      <= req_virtual_page[SLOT_BITS-1:0];
         spare_tbl_ff <= req_spare_table_frame[FRAME_BITS-1:0];
         spare_pg_ff  <= req_spare_page_frame[FRAME_BITS-1:0];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (state_ff == FSM_EXEC) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule

// ----- rtl/demand_paging_table_manager.sv -----
// Top level of the demand paging table manager: directory and page entry
// memories around the dptm_ctrl sequencer. Depends on dptm_pkg, dptm_ram, dptm_ctrl.
//
//   channel   handshake              payload
//   request   start / busy           req_operation, req_virtual_page,
//                                    req_fault_not_present, req_spare_*_frame
//   result    rsp_strobe (1 cycle)   rsp_status, rsp_took_*_frame,
//                                    rsp_released_frame
//   register  csr_valid / csr_ready  csr_data (first_table_frame)
//
// After reset a clearing pass writes all 2**(DIR_INDEX_BITS+TABLE_INDEX_BITS)
// page entries (1048576 at the defaults), one page entry per cycle; busy is high.
// Each item is read and then written back: the accept edge reads the directory
// and page entry, and FSM_EXEC modifies and writes back, with busy still high.
// The result beat is on the ports in the cycle after FSM_EXEC, one cycle only;
// the receiver cannot stall it, and a new item may be accepted in that cycle.
// csr_ready is low while an item executes and while the directory is cleared.
`timescale 1ns / 1ps

module demand_paging_table_manager #(
   parameter int DIR_INDEX_BITS = 10,
   parameter int TABLE_INDEX_BITS = 10,
   parameter int FRAME_BITS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_operation,
   input  logic [dptm_pkg::VPAGE_W-1:0]         req_virtual_page,
   input  logic                                 req_fault_not_present,
   input  logic [dptm_pkg::FRAME_W-1:0]         req_spare_table_frame,
   input  logic [dptm_pkg::FRAME_W-1:0]         req_spare_page_frame,
   output logic                                 rsp_strobe,
   output logic [dptm_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_took_table_frame,
   output logic                                 rsp_took_page_frame,
   output logic [dptm_pkg::FRAME_W-1:0]         rsp_released_frame,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dptm_pkg::FRAME_W-1:0]         csr_data
);

   import dptm_pkg::*;

   localparam int SLOT_BITS = DIR_INDEX_BITS + TABLE_INDEX_BITS;

   logic                      dir_rd_en;
   logic [DIR_INDEX_BITS-1:0] dir_rd_addr;
   logic [FRAME_BITS:0]       dir_rd_data;
   logic                      dir_wr_en;
   logic [DIR_INDEX_BITS-1:0] dir_wr_addr;
   logic [FRAME_BITS:0]       dir_wr_data;
   logic                      pg_rd_en;
   logic [SLOT_BITS-1:0]      pg_rd_addr;
   logic [FRAME_BITS:0]       pg_rd_data;
   logic                      pg_wr_en;
   logic [SLOT_BITS-1:0]      pg_wr_addr;
   logic [FRAME_BITS:0]       pg_wr_data;
   rsp_type                   rsp;

   // Directory: present bit and table frame per entry
   dptm_ram #(
      .WIDTH     (FRAME_BITS + 1),
      .ADDR_BITS (DIR_INDEX_BITS)
   ) u_dir_ram (
      .clock   (clock),
      .rd_en   (dir_rd_en),
      .rd_addr (dir_rd_addr),
      .rd_data (dir_rd_data),
      .wr_en   (dir_wr_en),
      .wr_addr (dir_wr_addr),
      .wr_data (dir_wr_data)
   );

   // Page entries: present bit and page frame per slot
   dptm_ram #(
      .WIDTH     (FRAME_BITS + 1),
      .ADDR_BITS (SLOT_BITS)
   ) u_page_ram (
      .clock   (clock),
      .rd_en   (pg_rd_en),
      .rd_addr (pg_rd_addr),
      .rd_data (pg_rd_data),
      .wr_en   (pg_wr_en),
      .wr_addr (pg_wr_addr),
      .wr_data (pg_wr_data)
   );

   dptm_ctrl #(
      .DIR_INDEX_BITS   (DIR_INDEX_BITS),
      .TABLE_INDEX_BITS (TABLE_INDEX_BITS),
      .FRAME_BITS       (FRAME_BITS)
   ) u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_operation         (req_operation),
      .req_virtual_page      (req_virtual_page),
      .req_fault_not_present (req_fault_not_present),
      .req_spare_table_frame (req_spare_table_frame),
      .req_spare_page_frame  (req_spare_page_frame),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data),
      .dir_rd_en             (dir_rd_en),
      .dir_rd_addr           (dir_rd_addr),
      .dir_rd_data           (dir_rd_data),
      .dir_wr_en             (dir_wr_en),
      .dir_wr_addr           (dir_wr_addr),
      .dir_wr_data           (dir_wr_data),
      .pg_rd_en              (pg_rd_en),
      .pg_rd_addr            (pg_rd_addr),
      .pg_rd_data            (pg_rd_data),
      .pg_wr_en              (pg_wr_en),
      .pg_wr_addr            (pg_wr_addr),
      .pg_wr_data            (pg_wr_data),
      .rsp_strobe            (rsp_strobe),
      .rsp                   (rsp)
   );

   // Unpack the result beat onto its ports
   assign rsp_status           = rsp.status;
   assign rsp_took_table_frame = rsp.took_table_frame;
   assign rsp_took_page_frame  = rsp.took_page_frame;
   assign rsp_released_frame   = rsp.released_frame;

endmodule
